>>> rtl/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants for the earliest-deadline-first ready queue.
// ----------------------------------------------------------------------------
package edf_pkg;

   localparam int EDF_QUEUE_DEPTH = 16;
   localparam int KIND_W          = 4;
   localparam int DEADLINE_W      = 32;
   localparam int QCOUNT_W        = 5;

   typedef enum logic {
      OP_ENQUEUE  = 1'b0,
      OP_DISPATCH = 1'b1
   } edf_op_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED   = 2'd0,
      ST_DISPATCHED = 2'd1,
      ST_FULL       = 2'd2,
      ST_EMPTY      = 2'd3
   } edf_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } edf_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [DEADLINE_W-1:0] deadline;
   } edf_entry_type;

   typedef struct packed {
      edf_status_type        status;
      logic [KIND_W-1:0]     kind;
      logic [DEADLINE_W-1:0] deadline;
      logic [QCOUNT_W-1:0]   count;
   } edf_result_type;

endpackage

>>> rtl/edf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_if
// Valid/ready channels for request and response beats of the ready queue.
// ----------------------------------------------------------------------------
interface edf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [edf_pkg::KIND_W-1:0]       task_kind;
   logic [edf_pkg::DEADLINE_W-1:0]   deadline;

   modport source (output valid, output opcode, output task_kind, output deadline,
                   input ready);
   modport sink   (input valid, input opcode, input task_kind, input deadline,
                   output ready);
endinterface

interface edf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [edf_pkg::KIND_W-1:0]       out_kind;
   logic [edf_pkg::DEADLINE_W-1:0]   out_deadline;
   logic [edf_pkg::QCOUNT_W-1:0]     queue_count;

   modport source (output valid, output status, output out_kind, output out_deadline,
                   output queue_count, input ready);
   modport sink   (input valid, input status, input out_kind, input out_deadline,
                   input queue_count, output ready);
endinterface

>>> rtl/edf_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module edf_entry_ram #(
   parameter int DEPTH  = edf_pkg::EDF_QUEUE_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [ADDR_W-1:0]     waddr,
   input  edf_pkg::edf_entry_type wdata,
   input  logic [ADDR_W-1:0]     raddr,
   output edf_pkg::edf_entry_type rdata
);

   edf_pkg::edf_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/edf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer with one shared deadline comparator: scan for the minimum,
// then close the gap one entry per cycle.
// ----------------------------------------------------------------------------
module edf_ctrl #(
   parameter int QUEUE_DEPTH = edf_pkg::EDF_QUEUE_DEPTH,
   parameter int IDX_W       = $clog2(QUEUE_DEPTH),
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [edf_pkg::KIND_W-1:0]      req_task_kind,
   input  logic [edf_pkg::DEADLINE_W-1:0]  req_deadline,
   input  logic                            out_free,
   output logic                            res_valid,
   output edf_pkg::edf_result_type         res,
   output logic                            ram_we,
   output logic [IDX_W-1:0]                ram_waddr,
   output edf_pkg::edf_entry_type          ram_wdata,
   output logic [IDX_W-1:0]                ram_raddr,
   input  edf_pkg::edf_entry_type          ram_rdata
);

   edf_pkg::edf_state_type              state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [IDX_W-1:0]                    pos_ff, pos_in;
   logic [IDX_W-1:0]                    best_idx_ff, best_idx_in;
   logic [edf_pkg::KIND_W-1:0]          best_kind_ff, best_kind_in;
   logic [edf_pkg::DEADLINE_W-1:0]      best_dl_ff, best_dl_in;
   edf_pkg::edf_status_type             status_ff, status_in;

   logic                                take;
   logic [IDX_W-1:0]                    best_next_idx;
   logic [CNT_W-1:0]                    last_idx;
   logic [CNT_W+edf_pkg::QCOUNT_W-1:0]  count_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edf_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      best_idx_ff  <= best_idx_in;
      best_kind_ff <= best_kind_in;
      best_dl_ff   <= best_dl_in;
      status_ff    <= status_in;
   end

   // strict less-than keeps the oldest entry on equal deadlines
   assign take          = (pos_ff == '0) || (ram_rdata.deadline < best_dl_ff);
   assign best_next_idx = take ? pos_ff : best_idx_ff;
   assign last_idx      = count_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      best_idx_in  = best_idx_ff;
      best_kind_in = best_kind_ff;
      best_dl_in   = best_dl_ff;
      status_in    = status_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = pos_ff + IDX_W'(1);

      unique case (state_ff)
         edf_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               best_kind_in = '0;
               best_dl_in   = '0;
               if (req_opcode == edf_pkg::OP_ENQUEUE) begin
                  state_in = edf_pkg::S_FINISH;
                  if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     status_in = edf_pkg::ST_FULL;
                  end else begin
                     ram_we             = 1'b1;
                     ram_waddr          = count_ff[IDX_W-1:0];
                     ram_wdata.kind     = req_task_kind;
                     ram_wdata.deadline = req_deadline;
                     count_in           = count_ff + CNT_W'(1);
                     status_in          = edf_pkg::ST_ENQUEUED;
                  end
               end else if (count_ff == '0) begin
                  status_in = edf_pkg::ST_EMPTY;
                  state_in  = edf_pkg::S_FINISH;
               end else begin
                  ram_raddr = '0;
                  pos_in    = '0;
                  state_in  = edf_pkg::S_SCAN;
               end
            end
         end
         edf_pkg::S_SCAN: begin
            best_idx_in = best_next_idx;
            if (take) begin
               best_kind_in = ram_rdata.kind;
               best_dl_in   = ram_rdata.deadline;
            end
            if (CNT_W'(pos_ff) == last_idx) begin
               status_in = edf_pkg::ST_DISPATCHED;
               if (CNT_W'(best_next_idx) == last_idx) begin
                  count_in = last_idx;
                  state_in = edf_pkg::S_FINISH;
               end else begin
                  ram_raddr = best_next_idx + IDX_W'(1);
                  pos_in    = best_next_idx;
                  state_in  = edf_pkg::S_SHIFT;
               end
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         edf_pkg::S_SHIFT: begin
            ram_we = 1'b1;
            if (CNT_W'(pos_ff) == count_ff - CNT_W'(2)) begin
               count_in = last_idx;
               state_in = edf_pkg::S_FINISH;
            end else begin
               ram_raddr = pos_ff + IDX_W'(2);
               pos_in    = pos_ff + IDX_W'(1);
            end
         end
         edf_pkg::S_FINISH: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = edf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = edf_pkg::S_IDLE;
         end
      endcase
   end

   assign count_wide   = (CNT_W + edf_pkg::QCOUNT_W)'(count_ff);
   assign res.status   = status_ff;
   assign res.kind     = best_kind_ff;
   assign res.deadline = best_dl_ff;
   assign res.count    = count_wide[edf_pkg::QCOUNT_W-1:0];

endmodule

>>> rtl/edf_ready_queue.sv
`timescale 1ns / 1ps
// Enqueue, full or empty moves from the request beat to the finish state; its result
// enters the response register once it is free. Dispatch first scans the held entries,
// the shared comparator reading one entry per cycle, then one slot moves per cycle to
// close the gap. A new request is taken only in idle, after the result has been loaded.
// Reset clears the entry count and the sequencer; entry storage is not cleared.
// ----------------------------------------------------------------------------
// edf_ready_queue
// Earliest-deadline-first ready queue: enqueue appends, dispatch removes the
// entry with the smallest deadline (oldest wins ties), order otherwise kept.
// ----------------------------------------------------------------------------
module edf_ready_queue #(
   parameter int QUEUE_DEPTH = edf_pkg::EDF_QUEUE_DEPTH
) (
   input logic         clock,
   input logic         reset,
   edf_req_if.sink     req_bus,
   edf_rsp_if.source   rsp_bus
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                     out_free;
   logic                     res_valid;
   edf_pkg::edf_result_type  res;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [IDX_W-1:0]         ram_raddr;
   edf_pkg::edf_entry_type   ram_wdata;
   edf_pkg::edf_entry_type   ram_rdata;

   // response register: parts the sequencer from the response channel
   logic                     rsp_valid_ff, rsp_valid_in;
   edf_pkg::edf_result_type  rsp_data_ff, rsp_data_in;

   edf_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_opcode    (req_bus.opcode),
      .req_task_kind (req_bus.task_kind),
      .req_deadline  (req_bus.deadline),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   edf_entry_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // the slot is free when empty or when its beat leaves this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         // load the finished result
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_bus.ready) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_data_ff.status;
   assign rsp_bus.out_kind     = rsp_data_ff.kind;
   assign rsp_bus.out_deadline = rsp_data_ff.deadline;
   assign rsp_bus.queue_count  = rsp_data_ff.count;

endmodule

>>> dv/tb_edf_ready_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edf_ready_queue
// Self-checking bench for the earliest-deadline-first ready queue. A shadow
// copy of the queue predicts every response from the accepted request beats.
// Stimulus runs a short directed pass over empty, full and tie cases, then a
// long random pass whose enqueue bias swings the queue between empty and full.
// Both sides idle at random, and the response side holds off once for a long
// stretch so that the queue backs up into the request channel.
// ----------------------------------------------------------------------------
module tb_edf_ready_queue;

   localparam int DEPTH       = edf_pkg::EDF_QUEUE_DEPTH;
   localparam int KIND_W      = edf_pkg::KIND_W;
   localparam int DEADLINE_W  = edf_pkg::DEADLINE_W;
   localparam int QCOUNT_W    = edf_pkg::QCOUNT_W;
   localparam int RAND_ITEMS  = 1550;
   localparam int HOLD_CYCLES = 250;

   // One request beat waiting to go out, with the idle cycles ahead of it.
   typedef struct {
      edf_pkg::edf_op_type   op;
      logic [KIND_W-1:0]     kind;
      logic [DEADLINE_W-1:0] deadline;
      int                    gap;
   } queue_request_type;

   logic clock;
   logic reset;

   edf_req_if req_bus ();
   edf_rsp_if rsp_bus ();

   edf_ready_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Request beats still to be sent; the head is the one on the bus.
   queue_request_type request_backlog[$];
   // Responses predicted from accepted requests, oldest first.
   edf_pkg::edf_result_type due_responses[$];

   // Shadow copy of the queue contents, oldest entry at slot 0.
   logic [DEADLINE_W-1:0] shadow_deadline[DEPTH];
   logic [KIND_W-1:0]     shadow_kind[DEPTH];
   int                    shadow_count = 0;

   int  mismatches   = 0;
   int  req_taken    = 0;
   int  stim_total   = 0;
   int  status_seen[4] = '{0, 0, 0, 0};
   int  send_idle;
   int  recv_wait;
   int  recv_beats;
   bit  rsp_hold     = 1'b0;
   edf_pkg::edf_result_type checked;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive every input to a known value before the first edge.
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = edf_pkg::OP_ENQUEUE;
      req_bus.task_kind = '0;
      req_bus.deadline  = '0;
      rsp_bus.ready     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one request to the shadow queue and return the response it earns.
   function automatic edf_pkg::edf_result_type apply_queue_op(
      input edf_pkg::edf_op_type   op,
      input logic [KIND_W-1:0]     kind,
      input logic [DEADLINE_W-1:0] deadline
   );
      edf_pkg::edf_result_type res;
      int best;
      int i;
      res = '0;
      if (op == edf_pkg::OP_ENQUEUE) begin
         if (shadow_count >= DEPTH) begin
            res.status = edf_pkg::ST_FULL;
         end else begin
            shadow_deadline[shadow_count] = deadline;
            shadow_kind[shadow_count]     = kind;
            shadow_count++;
            res.status = edf_pkg::ST_ENQUEUED;
         end
      end else if (shadow_count == 0) begin
         res.status = edf_pkg::ST_EMPTY;
      end else begin
         // Strict less-than keeps the oldest entry on a deadline tie.
         best = 0;
         for (i = 1; i < shadow_count; i++) begin
            if (shadow_deadline[i] < shadow_deadline[best]) best = i;
         end
         res.kind     = shadow_kind[best];
         res.deadline = shadow_deadline[best];
         // Close the gap, keeping insertion order of the rest.
         for (i = best; i < shadow_count - 1; i++) begin
            shadow_deadline[i] = shadow_deadline[i + 1];
            shadow_kind[i]     = shadow_kind[i + 1];
         end
         shadow_count--;
         res.status = edf_pkg::ST_DISPATCHED;
      end
      res.count = QCOUNT_W'(shadow_count);
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Queue one request; the first stretch of every 300 and the window that starts
   // with the long response hold-off go out back to back.
   task automatic add_request(input edf_pkg::edf_op_type op,
                              input logic [KIND_W-1:0] kind,
                              input logic [DEADLINE_W-1:0] deadline);
      queue_request_type item;
      item.op       = op;
      item.kind     = kind;
      item.deadline = deadline;
      if ((stim_total % 300) < 80 || (stim_total >= 400 && stim_total < 650))
         item.gap = 0;
      else
         item.gap = $urandom_range(0, 5);
      request_backlog.insert(request_backlog.size(), item);
      stim_total++;
   endtask

   // Request driver: hold a beat until taken, then idle for the next item's
   // gap before offering it.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_idle     <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) request_backlog.delete(0);
         if (req_bus.valid && !req_bus.ready) begin
            // hold the current beat
         end else if (request_backlog.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (send_idle < request_backlog[0].gap) begin
            req_bus.valid <= 1'b0;
            send_idle     <= send_idle + 1;
         end else begin
            req_bus.valid     <= 1'b1;
            req_bus.opcode    <= request_backlog[0].op;
            req_bus.task_kind <= request_backlog[0].kind;
            req_bus.deadline  <= request_backlog[0].deadline;
            send_idle         <= 0;
         end
      end
   end

   // Response receiver: after each beat draw a random stall, except for a
   // stall-free stretch of 120 beats out of every 400.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_wait     <= 0;
         recv_beats    <= 0;
      end else if (rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         stall = ((recv_beats % 400) < 120) ? 0 : $urandom_range(0, 5);
         recv_beats    <= recv_beats + 1;
         rsp_bus.ready <= (stall == 0);
         recv_wait     <= stall;
      end else if (recv_wait > 0) begin
         rsp_bus.ready <= (recv_wait == 1);
         recv_wait     <= recv_wait - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Long hold-off: stop taking responses for a fixed stretch while the
   // sender keeps offering beats back to back, so the queue stalls its input.
   initial begin
      wait (req_taken >= 400);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   // Monitor: check the response beat first, then predict from the request
   // beat taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_responses.size() == 0) begin
               mismatches++;
               $display("%0t ns: stray response, expected none, actual %0h/%0h/%0h/%0h",
                        $time, rsp_bus.status, rsp_bus.out_kind, rsp_bus.out_deadline,
                        rsp_bus.queue_count);
            end else begin
               checked = due_responses.pop_front();
               check_field("status", 32'(checked.status), 32'(rsp_bus.status));
               check_field("out_kind", 32'(checked.kind), 32'(rsp_bus.out_kind));
               check_field("out_deadline", checked.deadline, rsp_bus.out_deadline);
               check_field("queue_count", 32'(checked.count), 32'(rsp_bus.queue_count));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            checked = apply_queue_op(edf_pkg::edf_op_type'(req_bus.opcode),
                                     req_bus.task_kind, req_bus.deadline);
            status_seen[checked.status]++;
            due_responses.insert(due_responses.size(), checked);
            req_taken++;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [DEADLINE_W-1:0] fill_deadline[DEPTH];
      int enq_bias[5];
      int pct;
      int n;
      logic [DEADLINE_W-1:0] dl;

      fill_deadline = '{32'd1000, 32'd50, 32'd50, 32'hFFFF_FFFF, 32'h8000_0000, 32'd7,
                        32'd0, 32'd50, 32'd0, 32'h7FFF_FFFF, 32'd3, 32'd3,
                        32'hFFFF_FFFE, 32'd1, 32'd2, 32'd0};
      enq_bias = '{85, 60, 45, 30, 12};

      // Directed: dispatch from an empty queue with all-ones ignored fields.
      add_request(edf_pkg::OP_DISPATCH, 4'hF, 32'hFFFF_FFFF);
      // Extremes of kind and deadline, drained in deadline order.
      add_request(edf_pkg::OP_ENQUEUE, 4'h0, 32'h0);
      add_request(edf_pkg::OP_ENQUEUE, 4'hF, 32'hFFFF_FFFF);
      add_request(edf_pkg::OP_DISPATCH, 4'h0, 32'h0);
      add_request(edf_pkg::OP_DISPATCH, 4'h5, 32'h1234_5678);
      // Fill to the brim with ties, then overflow once.
      for (n = 0; n < DEPTH; n++)
         add_request(edf_pkg::OP_ENQUEUE, n[KIND_W-1:0], fill_deadline[n]);
      add_request(edf_pkg::OP_ENQUEUE, 4'h9, 32'h0);
      // Three zero-deadline ties, the last one sitting in the tail slot.
      repeat (3) add_request(edf_pkg::OP_DISPATCH, 4'hA, 32'hDEAD_BEEF);

      // Random: the enqueue bias shifts every 60 items to sweep the fill level.
      for (n = 0; n < RAND_ITEMS; n++) begin
         pct = enq_bias[(n / 60) % 5];
         if ($urandom_range(0, 99) < pct) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: dl = $urandom;
               4, 5, 6:    dl = $urandom_range(0, 15);
               7:          dl = 32'h0;
               8:          dl = 32'hFFFF_FFFF;
               default:    dl = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            endcase
            add_request(edf_pkg::OP_ENQUEUE, KIND_W'($urandom_range(0, 15)), dl);
         end else begin
            add_request(edf_pkg::OP_DISPATCH, KIND_W'($urandom_range(0, 15)), $urandom);
         end
      end

      // Drain: all beats sent, all responses back, then a dispatch's worth
      // of extra cycles to catch stray beats.
      wait (reset === 1'b0);
      wait (request_backlog.size() == 0 && req_bus.valid === 1'b0);
      wait (due_responses.size() == 0);
      repeat (2 * DEPTH + 8) @(posedge clock);

      $display("Ran %0d request beats: %0d enqueued, %0d dispatched, %0d full drops, %0d empty",
               req_taken, status_seen[edf_pkg::ST_ENQUEUED],
               status_seen[edf_pkg::ST_DISPATCHED], status_seen[edf_pkg::ST_FULL],
               status_seen[edf_pkg::ST_EMPTY]);
      $display("Response side held off once for %0d cycles with the sender streaming",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
